// ===== hdl/priority_ready_queue_with_sleep_unit_defines.svh =====
// ----------------------------------------------------------------------------
// priority_ready_queue_with_sleep_unit_defines
// Assertion helpers for the scheduler block.
// ----------------------------------------------------------------------------
`ifndef PRIORITY_READY_QUEUE_WITH_SLEEP_UNIT_DEFINES_SVH
`define PRIORITY_READY_QUEUE_WITH_SLEEP_UNIT_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define PRQS_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define PRQS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/prqs_pkg.sv =====
// ----------------------------------------------------------------------------
// prqs_pkg
// Shared constants and request codes of the priority scheduler.
// ----------------------------------------------------------------------------
`default_nettype none

package prqs_pkg;

    localparam int READY_DEPTH_DEF = 16;
    localparam int SLEEP_DEPTH_DEF = 16;
    localparam int ID_BITS_DEF     = 8;

    localparam int PRIO_BITS = 6;
    localparam int TICK_BITS = 63;
    localparam int IN_TASK_BITS = 8;
    localparam int CNT_BITS  = 5;

    typedef enum logic [1:0] {
        REQ_READY = 2'd0,
        REQ_SLEEP = 2'd1,
        REQ_TICK  = 2'd2,
        REQ_POP   = 2'd3
    } req_t;

    localparam logic [1:0] ERR_OK         = 2'd0;
    localparam logic [1:0] ERR_READY_FULL = 2'd1;
    localparam logic [1:0] ERR_SLEEP_FULL = 2'd2;

endpackage

`default_nettype wire

// ===== hdl/prqs_ram.sv =====
// ----------------------------------------------------------------------------
// prqs_ram
// Simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module prqs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ===== hdl/priority_ready_queue_with_sleep_unit.sv =====
// ----------------------------------------------------------------------------
// priority_ready_queue_with_sleep_unit
// Task scheduler: priority-sorted ready queue plus a timed sleep table.
// ----------------------------------------------------------------------------
// Usage:
//  - Slave channel takes one request word: s_tuser is the request kind
//    (make ready, sleep, timer tick, pop); s_tdata carries task id,
//    priority and tick value.
//  - Master channel returns exactly one result word per request.
//  - One request is worked at a time. s_tready is high while the engine
//    is idle; a finished result sits in the output register, so the next
//    request is taken even while the receiver stalls. A new result waits
//    for that register to drain.
//  - Flow per request: sleep or a full-queue error go from dispatch to the
//    result; pop reads the head unless empty; make ready walks back from the
//    tail, moving each lower-priority entry one slot back, up to the head or an
//    entry of equal or higher priority; tick scans all sleepers and inserts each
//    woken one likewise. Each entry takes a read/compare pair (registered RAM read).
//  - Reset (aresetn low, synchronous) empties both stores and sets the
//    earliest wake to all ones. There is no clearing pass: entries past
//    the fill counts are never read.
// ----------------------------------------------------------------------------
`default_nettype none
`include "priority_ready_queue_with_sleep_unit_defines.svh"

module priority_ready_queue_with_sleep_unit #(
    parameter int READY_DEPTH = prqs_pkg::READY_DEPTH_DEF,
    parameter int SLEEP_DEPTH = prqs_pkg::SLEEP_DEPTH_DEF,
    parameter int ID_BITS     = prqs_pkg::ID_BITS_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // [7:0] task_id, [13:8] priority_req, [76:14] tick_value, rest zero
    input  wire logic [79:0] s_tdata,
    // [1:0] req_type
    input  wire logic [1:0]  s_tuser,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // [7:0] next_task, [8] next_valid, [71:9] earliest_wake,
    // [76:72] woken_count, [81:77] ready_count, [86:82] sleep_count,
    // [88:87] error_code, rest zero
    output logic [95:0]      m_tdata
);

    import prqs_pkg::*;

    localparam int RA = $clog2(READY_DEPTH);
    localparam int RC = $clog2(READY_DEPTH + 1);
    localparam int SA = $clog2(SLEEP_DEPTH);
    localparam int SC = $clog2(SLEEP_DEPTH + 1);
    localparam int RW = ID_BITS + PRIO_BITS;
    localparam int SW = ID_BITS + PRIO_BITS + TICK_BITS;

    typedef enum logic [2:0] {
        S_IDLE, S_DISPATCH, S_RQ_ISSUE, S_RQ_CMP,
        S_POP_WAIT, S_SL_ISSUE, S_SL_CMP, S_RESULT
    } state_t;

    state_t               state_reg;
    req_t                 req_reg;
    logic [ID_BITS-1:0]   id_reg;
    logic [PRIO_BITS-1:0] prio_reg;
    logic [TICK_BITS-1:0] tick_reg;

    // ready queue: circular, sorted from head
    logic [RA-1:0]        head_reg;
    logic [RC-1:0]        rfill_reg;
    logic [RA-1:0]        k_reg;
    logic [ID_BITS-1:0]   ins_id_reg;
    logic [PRIO_BITS-1:0] ins_prio_reg;
    logic                 ins_tick_reg;

    // sleep table, in sleep order
    logic [SC-1:0]        sfill_reg;
    logic [SC-1:0]        r_reg;
    logic [SC-1:0]        w_reg;
    logic [TICK_BITS-1:0] min_reg;
    logic [TICK_BITS-1:0] run_min_reg;

    logic [CNT_BITS-1:0]  woken_reg;
    logic [1:0]           err_reg;
    logic [ID_BITS-1:0]   next_task_reg;
    logic                 next_valid_reg;
    logic                 m_tvalid_reg;
    logic [95:0]          m_tdata_reg;

    logic                 rq_we;
    logic [RA-1:0]        rq_waddr;
    logic [RW-1:0]        rq_wdata;
    logic [RA-1:0]        rq_raddr;
    logic [RW-1:0]        rq_rdata;
    logic                 sq_we;
    logic [SA-1:0]        sq_waddr;
    logic [SW-1:0]        sq_wdata;
    logic [SW-1:0]        sq_rdata;

    logic [PRIO_BITS-1:0] rq_rd_prio;
    logic [ID_BITS-1:0]   rq_rd_id;
    logic [TICK_BITS-1:0] sq_rd_wake;
    logic [PRIO_BITS-1:0] sq_rd_prio;
    logic [ID_BITS-1:0]   sq_rd_id;
    logic                 s_acc;
    logic                 out_free;

    // queue slot k relative to head, wrapped into the ring
    function automatic logic [RA-1:0] rq_addr(input logic [RA-1:0] k);
        logic [RA:0] s;
        s = {1'b0, head_reg} + {1'b0, k};
        if (s >= (RA+1)'(READY_DEPTH)) begin
            s = s - (RA+1)'(READY_DEPTH);
        end
        return s[RA-1:0];
    endfunction

    assign rq_rd_id   = rq_rdata[ID_BITS-1:0];
    assign rq_rd_prio = rq_rdata[RW-1 -: PRIO_BITS];
    assign sq_rd_id   = sq_rdata[ID_BITS-1:0];
    assign sq_rd_prio = sq_rdata[ID_BITS +: PRIO_BITS];
    assign sq_rd_wake = sq_rdata[SW-1 -: TICK_BITS];

    assign s_tready = (state_reg == S_IDLE);
    assign s_acc    = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // RAM port control
    always_comb begin
        rq_we    = 1'b0;
        rq_waddr = rq_addr(k_reg);
        rq_wdata = {ins_prio_reg, ins_id_reg};
        rq_raddr = (state_reg == S_RQ_ISSUE) ? rq_addr(k_reg - RA'(1)) : rq_addr('0);
        if (state_reg == S_RQ_ISSUE && k_reg == '0) begin
            rq_we = 1'b1;
        end
        if (state_reg == S_RQ_CMP) begin
            rq_we = 1'b1;
            // entry moves one slot back while it ranks below the new one
            if (rq_rd_prio < ins_prio_reg) begin
                rq_wdata = rq_rdata;
            end
        end

        sq_we    = 1'b0;
        sq_waddr = sfill_reg[SA-1:0];
        sq_wdata = {tick_reg, prio_reg, id_reg};
        if (state_reg == S_DISPATCH && req_reg == REQ_SLEEP &&
            sfill_reg != SC'(SLEEP_DEPTH)) begin
            sq_we = 1'b1;
        end
        if (state_reg == S_SL_CMP && sq_rd_wake > tick_reg) begin
            // survivor compacts down to the write pointer
            sq_we    = 1'b1;
            sq_waddr = w_reg[SA-1:0];
            sq_wdata = sq_rdata;
        end
    end

    prqs_ram #(.WIDTH(RW), .DEPTH(READY_DEPTH)) u_ready_ram (
        .aclk  (aclk),
        .we    (rq_we),
        .waddr (rq_waddr),
        .wdata (rq_wdata),
        .raddr (rq_raddr),
        .rdata (rq_rdata)
    );

    prqs_ram #(.WIDTH(SW), .DEPTH(SLEEP_DEPTH)) u_sleep_ram (
        .aclk  (aclk),
        .we    (sq_we),
        .waddr (sq_waddr),
        .wdata (sq_wdata),
        .raddr (r_reg[SA-1:0]),
        .rdata (sq_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            head_reg     <= '0;
            rfill_reg    <= '0;
            sfill_reg    <= '0;
            min_reg      <= '1;
            m_tvalid_reg <= 1'b0;
        end else begin
            // drained word; a new result in S_RESULT reloads it below
            if (m_tvalid_reg && m_tready && state_reg != S_RESULT) begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (s_acc) begin
                        req_reg        <= req_t'(s_tuser);
                        id_reg         <= ID_BITS'(s_tdata[7:0]);
                        prio_reg       <= s_tdata[13:8];
                        tick_reg       <= s_tdata[76:14];
                        woken_reg      <= '0;
                        err_reg        <= ERR_OK;
                        next_task_reg  <= '0;
                        next_valid_reg <= 1'b0;
                        state_reg      <= S_DISPATCH;
                    end
                end
                S_DISPATCH: begin
                    unique case (req_reg)
                        REQ_READY: begin
                            ins_id_reg   <= id_reg;
                            ins_prio_reg <= prio_reg;
                            ins_tick_reg <= 1'b0;
                            k_reg        <= rfill_reg[RA-1:0];
                            if (rfill_reg == RC'(READY_DEPTH)) begin
                                err_reg   <= ERR_READY_FULL;
                                state_reg <= S_RESULT;
                            end else begin
                                state_reg <= S_RQ_ISSUE;
                            end
                        end
                        REQ_SLEEP: begin
                            if (sfill_reg == SC'(SLEEP_DEPTH)) begin
                                err_reg <= ERR_SLEEP_FULL;
                            end else begin
                                sfill_reg <= sfill_reg + SC'(1);
                                if (tick_reg < min_reg) begin
                                    min_reg <= tick_reg;
                                end
                            end
                            state_reg <= S_RESULT;
                        end
                        REQ_TICK: begin
                            r_reg       <= '0;
                            w_reg       <= '0;
                            run_min_reg <= '1;
                            state_reg   <= S_SL_ISSUE;
                        end
                        REQ_POP: begin
                            state_reg <= (rfill_reg == '0) ? S_RESULT : S_POP_WAIT;
                        end
                        default: state_reg <= S_RESULT;
                    endcase
                end
                S_RQ_ISSUE: begin
                    if (k_reg == '0) begin
                        rfill_reg <= rfill_reg + RC'(1);
                        if (ins_tick_reg) begin
                            woken_reg <= woken_reg + CNT_BITS'(1);
                            state_reg <= S_SL_ISSUE;
                        end else begin
                            state_reg <= S_RESULT;
                        end
                    end else begin
                        state_reg <= S_RQ_CMP;
                    end
                end
                S_RQ_CMP: begin
                    if (rq_rd_prio < ins_prio_reg) begin
                        k_reg     <= k_reg - RA'(1);
                        state_reg <= S_RQ_ISSUE;
                    end else begin
                        rfill_reg <= rfill_reg + RC'(1);
                        if (ins_tick_reg) begin
                            woken_reg <= woken_reg + CNT_BITS'(1);
                            state_reg <= S_SL_ISSUE;
                        end else begin
                            state_reg <= S_RESULT;
                        end
                    end
                end
                S_POP_WAIT: begin
                    next_task_reg  <= rq_rd_id;
                    next_valid_reg <= 1'b1;
                    head_reg       <= rq_addr(RA'(1));
                    rfill_reg      <= rfill_reg - RC'(1);
                    state_reg      <= S_RESULT;
                end
                S_SL_ISSUE: begin
                    if (r_reg == sfill_reg) begin
                        sfill_reg <= w_reg;
                        min_reg   <= run_min_reg;
                        state_reg <= S_RESULT;
                    end else begin
                        state_reg <= S_SL_CMP;
                    end
                end
                S_SL_CMP: begin
                    r_reg <= r_reg + SC'(1);
                    if (sq_rd_wake <= tick_reg) begin
                        // due: leaves the table, into the ready queue if room
                        ins_id_reg   <= sq_rd_id;
                        ins_prio_reg <= sq_rd_prio;
                        ins_tick_reg <= 1'b1;
                        k_reg        <= rfill_reg[RA-1:0];
                        if (rfill_reg == RC'(READY_DEPTH)) begin
                            err_reg   <= ERR_READY_FULL;
                            state_reg <= S_SL_ISSUE;
                        end else begin
                            state_reg <= S_RQ_ISSUE;
                        end
                    end else begin
                        w_reg <= w_reg + SC'(1);
                        if (sq_rd_wake < run_min_reg) begin
                            run_min_reg <= sq_rd_wake;
                        end
                        state_reg <= S_SL_ISSUE;
                    end
                end
                S_RESULT: begin
                    if (out_free) begin
                        m_tvalid_reg <= 1'b1;
                        m_tdata_reg  <= {7'd0, err_reg, CNT_BITS'(sfill_reg),
                                         CNT_BITS'(rfill_reg), woken_reg, min_reg,
                                         next_valid_reg, IN_TASK_BITS'(next_task_reg)};
                        state_reg    <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    `PRQS_ASSERT_IMP(a_rfill_bound, 1'b1, rfill_reg <= RC'(READY_DEPTH), "ready fill overflow")
    `PRQS_ASSERT_IMP(a_sfill_bound, 1'b1, sfill_reg <= SC'(SLEEP_DEPTH), "sleep fill overflow")
    `PRQS_ASSERT_NEXT(a_acc_busy, s_acc, state_reg == S_DISPATCH, "accepted word not dispatched")
    `PRQS_ASSERT_IMP(a_we_busy, rq_we || sq_we, state_reg != S_IDLE, "RAM write while idle")

endmodule

`default_nettype wire
